@@ src/annexb_nal_extract_classify_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the NAL extractor/classifier RTL
// ----------------------------------------------------------------------------
`ifndef ANNEXB_NAL_EXTRACT_CLASSIFY_DEFINES_SVH
`define ANNEXB_NAL_EXTRACT_CLASSIFY_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ANX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("anx assertion failed");

// Next-cycle implication, checked out of reset.
`define ANX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("anx assertion failed");

`endif

@@ src/anx_pkg.sv @@
// ----------------------------------------------------------------------------
// anx_pkg
// Types, codes and constants of the Annex-B NAL extractor/classifier.
// ----------------------------------------------------------------------------
package anx_pkg;

    localparam int LEN_W  = 20;
    localparam int FILL_W = 25;

    localparam logic [LEN_W-1:0]  MAX_NAL      = LEN_W'(524288);
    localparam logic [LEN_W-1:0]  LEN_TOO_LONG = LEN_W'(524289);
    localparam logic [FILL_W-1:0] CAP_RESET    = FILL_W'(20971520);
    localparam logic [LEN_W-1:0]  ENTRY_PREFIX = LEN_W'(4);

    // length limits per NAL class
    localparam logic [LEN_W-1:0] SPS_MIN_LEN   = LEN_W'(4);
    localparam logic [LEN_W-1:0] SPS_MAX_LEN   = LEN_W'(128);
    localparam logic [LEN_W-1:0] PPS_MIN_LEN   = LEN_W'(2);
    localparam logic [LEN_W-1:0] PPS_MAX_LEN   = LEN_W'(96);
    localparam logic [LEN_W-1:0] IDR_MIN_LEN   = LEN_W'(16);
    localparam logic [LEN_W-1:0] SLICE_MIN_LEN = LEN_W'(4);

    // stream actions
    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    // nal_unit_type values
    localparam logic [4:0] KIND_SLICE = 5'd1;
    localparam logic [4:0] KIND_IDR   = 5'd5;
    localparam logic [4:0] KIND_SPS   = 5'd7;
    localparam logic [4:0] KIND_PPS   = 5'd8;

    // verdict codes
    localparam logic [2:0] VERDICT_DROP  = 3'd0;
    localparam logic [2:0] VERDICT_SPS   = 3'd1;
    localparam logic [2:0] VERDICT_PPS   = 3'd2;
    localparam logic [2:0] VERDICT_IDR   = 3'd3;
    localparam logic [2:0] VERDICT_SLICE = 3'd4;

    // GOP cache actions
    localparam logic [1:0] GOP_NONE    = 2'd0;
    localparam logic [1:0] GOP_RESTART = 2'd1;
    localparam logic [1:0] GOP_APPEND  = 2'd2;
    localparam logic [1:0] GOP_SPILL   = 2'd3;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic       live_forward;
        logic       bootstrap_wanted;
    } in_item_t;

    // a start code closed a non-empty NAL
    typedef struct packed {
        logic             fire;
        logic [7:0]       header_byte;
        logic [7:0]       profile_byte;
        logic [LEN_W-1:0] kept_length;
        logic             too_long;
    } nal_close_t;

    typedef struct packed {
        logic              valid;
        logic [2:0]        verdict;
        logic [4:0]        nal_kind;
        logic [LEN_W-1:0]  nal_length;
        logic              forward_now;
        logic [1:0]        gop_action;
        logic [FILL_W-1:0] gop_fill;
        logic              bootstrap_request;
    } nal_result_t;

    function automatic logic profile_ok(input logic [7:0] p);
        logic ok;
        case (p) inside
            8'd66, 8'd77, 8'd88, 8'd100, 8'd110, 8'd122, 8'd244: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

@@ src/anx_in_if.sv @@
// ----------------------------------------------------------------------------
// anx_in_if
// Byte stream channel: one stream byte or restart per transaction.
// ----------------------------------------------------------------------------
interface anx_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;
    logic       live_forward;
    logic       bootstrap_wanted;

    modport source (output valid, action, data_byte, live_forward, bootstrap_wanted,
                    input ready);
    modport sink   (input valid, action, data_byte, live_forward, bootstrap_wanted,
                    output ready);
endinterface

@@ src/anx_out_if.sv @@
// ----------------------------------------------------------------------------
// anx_out_if
// Verdict channel: one classified NAL per transaction.
// ----------------------------------------------------------------------------
interface anx_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [4:0]  nal_kind;
    logic [19:0] nal_length;
    logic        forward_now;
    logic [1:0]  gop_action;
    logic [24:0] gop_fill;
    logic        bootstrap_request;

    modport source (output valid, verdict, nal_kind, nal_length, forward_now,
                    gop_action, gop_fill, bootstrap_request,
                    input ready);
    modport sink   (input valid, verdict, nal_kind, nal_length, forward_now,
                    gop_action, gop_fill, bootstrap_request,
                    output ready);
endinterface

@@ src/anx_cfg_if.sv @@
// ----------------------------------------------------------------------------
// anx_cfg_if
// Configuration write channel for the GOP cache capacity register.
// ----------------------------------------------------------------------------
interface anx_cfg_if;
    logic        valid;
    logic        ready;
    logic [24:0] gop_capacity;

    modport source (output valid, gop_capacity, input ready);
    modport sink   (input valid, gop_capacity, output ready);
endinterface

@@ src/annexb_nal_extract_classify.sv @@
// ----------------------------------------------------------------------------
// annexb_nal_extract_classify
// Annex-B NAL extractor and classifier, one stream byte per cycle while no result is stalled.
// ----------------------------------------------------------------------------
// Usage:
//   byte_stream : one transaction per stream byte (action 0) or per restart
//                 (action 1), carrying the client live/bootstrap flags.
//   result      : one transaction per completed non-empty NAL, issued when the
//                 following start code arrives; all other bytes give nothing.
//   cfg         : write of the GOP cache capacity; write only while idle.
// Throughput: one byte per cycle while no result waits on result.ready. The
//   scanner and classifier state updates are combinational logic, the widest
//   path being the 26-bit cache occupancy add and compare against the capacity.
// Path: the closing start code byte is captured in the input register, then
//   classified, and the verdict is registered onto result.
// Reset: all state clears, capacity returns to 20971520, no result pending.
// Stall: while a result waits on result.ready the input register holds at
//   most one more byte, and byte_stream.ready stays low until it is taken.
// ----------------------------------------------------------------------------
`include "annexb_nal_extract_classify_defines.svh"

module annexb_nal_extract_classify
    import anx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    anx_in_if.sink       byte_stream,
    anx_out_if.source    result,
    anx_cfg_if.sink      cfg
);

    logic              in_valid_reg, in_valid_next;
    in_item_t          in_item_reg;
    logic              out_valid_reg, out_valid_next;
    nal_result_t       out_reg;
    logic [FILL_W-1:0] gop_capacity_reg;

    logic        advance;
    logic        in_take;
    nal_close_t  close;
    nal_result_t res;

    assign advance = in_valid_reg && (!out_valid_reg || result.ready);
    assign in_take = byte_stream.valid && byte_stream.ready;

    assign byte_stream.ready = !in_valid_reg || advance;
    assign cfg.ready         = 1'b1;

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = res.valid;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            gop_capacity_reg <= CAP_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
                gop_capacity_reg <= cfg.gop_capacity;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.action           <= byte_stream.action;
            in_item_reg.data_byte        <= byte_stream.data_byte;
            in_item_reg.live_forward     <= byte_stream.live_forward;
            in_item_reg.bootstrap_wanted <= byte_stream.bootstrap_wanted;
        end
        if (advance && res.valid)
            out_reg <= res;
    end

    anx_scanner u_scanner (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_item_reg),
        .close (close)
    );

    anx_classifier u_classifier (
        .clk              (clk),
        .rst_n            (rst_n),
        .close            (close),
        .live_forward     (in_item_reg.live_forward),
        .bootstrap_wanted (in_item_reg.bootstrap_wanted),
        .gop_capacity     (gop_capacity_reg),
        .result           (res)
    );

    assign result.valid             = out_valid_reg;
    assign result.verdict           = out_reg.verdict;
    assign result.nal_kind          = out_reg.nal_kind;
    assign result.nal_length        = out_reg.nal_length;
    assign result.forward_now       = out_reg.forward_now;
    assign result.gop_action        = out_reg.gop_action;
    assign result.gop_fill          = out_reg.gop_fill;
    assign result.bootstrap_request = out_reg.bootstrap_request;

    `ANX_ASSERT_IMP(a_drop_quiet, clk, rst_n,
                    out_valid_reg && out_reg.verdict == VERDICT_DROP,
                    !out_reg.forward_now && out_reg.gop_action == GOP_NONE &&
                    !out_reg.bootstrap_request)
    `ANX_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid_reg && !result.ready,
                     out_valid_reg && $stable(out_reg))

endmodule

@@ src/anx_scanner.sv @@
// ----------------------------------------------------------------------------
// anx_scanner
// Start code detection, NAL length tracking and header capture.
// ----------------------------------------------------------------------------
`include "annexb_nal_extract_classify_defines.svh"

module anx_scanner
    import anx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  in_item_t   item,
    output nal_close_t close
);

    logic [1:0]       zero_run_reg, zero_run_next;
    logic             inside_nal_reg, inside_nal_next;
    logic [LEN_W-1:0] byte_count_reg, byte_count_next;
    logic [LEN_W-1:0] kept_length_reg, kept_length_next;
    logic             too_long_reg, too_long_next;
    logic [7:0]       header_byte_reg, header_byte_next;
    logic [7:0]       profile_byte_reg, profile_byte_next;

    logic [7:0] b;
    logic       start_code;

    assign b          = item.data_byte;
    assign start_code = (b == 8'd1) && (zero_run_reg == 2'd2);

    always_comb
    begin
        zero_run_next     = zero_run_reg;
        inside_nal_next   = inside_nal_reg;
        byte_count_next   = byte_count_reg;
        kept_length_next  = kept_length_reg;
        too_long_next     = too_long_reg;
        header_byte_next  = header_byte_reg;
        profile_byte_next = profile_byte_reg;

        close.fire         = 1'b0;
        close.header_byte  = header_byte_reg;
        close.profile_byte = profile_byte_reg;
        close.kept_length  = kept_length_reg;
        close.too_long     = too_long_reg;

        if (step)
        begin
            if (item.action == ACT_RESTART || start_code)
            begin
                close.fire        = (item.action == ACT_BYTE) && inside_nal_reg &&
                                    (kept_length_reg != '0);
                inside_nal_next   = (item.action == ACT_BYTE);
                zero_run_next     = 2'd0;
                byte_count_next   = '0;
                kept_length_next  = '0;
                too_long_next     = 1'b0;
                header_byte_next  = 8'd0;
                profile_byte_next = 8'd0;
            end
            else
            begin
                if (b == 8'd0)
                begin
                    if (zero_run_reg != 2'd2)
                        zero_run_next = zero_run_reg + 2'd1;
                end
                else
                begin
                    zero_run_next = 2'd0;
                end

                if (inside_nal_reg)
                begin
                    if (byte_count_reg == '0)
                        header_byte_next = b;
                    else if (byte_count_reg == LEN_W'(1))
                        profile_byte_next = b;
                    // saturates one past the limit
                    if (byte_count_reg <= MAX_NAL)
                        byte_count_next = byte_count_reg + LEN_W'(1);
                    if (b != 8'd0)
                    begin
                        kept_length_next = byte_count_next;
                        if (byte_count_next > MAX_NAL)
                            too_long_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_run_reg     <= 2'd0;
            inside_nal_reg   <= 1'b0;
            byte_count_reg   <= '0;
            kept_length_reg  <= '0;
            too_long_reg     <= 1'b0;
            header_byte_reg  <= 8'd0;
            profile_byte_reg <= 8'd0;
        end
        else
        begin
            zero_run_reg     <= zero_run_next;
            inside_nal_reg   <= inside_nal_next;
            byte_count_reg   <= byte_count_next;
            kept_length_reg  <= kept_length_next;
            too_long_reg     <= too_long_next;
            header_byte_reg  <= header_byte_next;
            profile_byte_reg <= profile_byte_next;
        end
    end

    `ANX_ASSERT_IMP(a_kept_le_count, clk, rst_n, 1'b1, kept_length_reg <= byte_count_reg)
    `ANX_ASSERT_IMP(a_too_long_len, clk, rst_n, too_long_reg, kept_length_reg == LEN_TOO_LONG)

endmodule

@@ src/anx_classifier.sv @@
// ----------------------------------------------------------------------------
// anx_classifier
// NAL verdict, parameter-set tracking and GOP cache accounting.
// ----------------------------------------------------------------------------
`include "annexb_nal_extract_classify_defines.svh"

module anx_classifier
    import anx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  nal_close_t        close,
    input  logic              live_forward,
    input  logic              bootstrap_wanted,
    input  logic [FILL_W-1:0] gop_capacity,
    output nal_result_t       result
);

    logic              sps_seen_reg, sps_seen_next;
    logic              pps_seen_reg, pps_seen_next;
    logic              gop_valid_reg, gop_valid_next;
    logic              gop_full_reg, gop_full_next;
    logic [FILL_W-1:0] gop_used_reg, gop_used_next;

    logic [4:0]        kind;
    logic              hok;
    logic [LEN_W-1:0]  len;
    logic [LEN_W:0]    need;
    logic [FILL_W-1:0] base;
    logic [FILL_W:0]   sum;
    logic              over;
    logic              eligible;

    assign kind     = close.header_byte[4:0];
    assign hok      = close.header_byte[6:5] != 2'b00;
    assign len      = close.kept_length;
    assign eligible = close.fire && !close.too_long && (len != '0) && !close.header_byte[7];

    // an IDR restarts the account, so its entry is checked against an empty cache
    assign base = (kind == KIND_IDR) ? '0 : gop_used_reg;
    assign need = {1'b0, len} + {1'b0, ENTRY_PREFIX};
    assign sum  = {1'b0, base} + (FILL_W + 1)'(need);
    assign over = sum > {1'b0, gop_capacity};

    always_comb
    begin
        sps_seen_next  = sps_seen_reg;
        pps_seen_next  = pps_seen_reg;
        gop_valid_next = gop_valid_reg;
        gop_full_next  = gop_full_reg;
        gop_used_next  = gop_used_reg;

        result.valid             = close.fire;
        result.verdict           = VERDICT_DROP;
        result.nal_kind          = kind;
        result.nal_length        = len;
        result.forward_now       = 1'b0;
        result.gop_action        = GOP_NONE;
        result.bootstrap_request = 1'b0;

        if (eligible)
        begin
            case (kind)
                KIND_SPS:
                begin
                    if (len >= SPS_MIN_LEN && len <= SPS_MAX_LEN && hok &&
                        profile_ok(close.profile_byte))
                    begin
                        result.verdict     = VERDICT_SPS;
                        result.forward_now = live_forward;
                        sps_seen_next      = 1'b1;
                    end
                end
                KIND_PPS:
                begin
                    if (len >= PPS_MIN_LEN && len <= PPS_MAX_LEN && hok)
                    begin
                        result.verdict     = VERDICT_PPS;
                        result.forward_now = live_forward;
                        pps_seen_next      = 1'b1;
                    end
                end
                KIND_IDR:
                begin
                    if (hok && len >= IDR_MIN_LEN && sps_seen_reg && pps_seen_reg)
                    begin
                        result.verdict     = VERDICT_IDR;
                        result.forward_now = live_forward;
                        gop_valid_next     = 1'b1;
                        gop_full_next      = over;
                        gop_used_next      = over ? '0 : sum[FILL_W-1:0];
                        result.gop_action  = over ? GOP_SPILL : GOP_RESTART;
                        result.bootstrap_request = !live_forward && bootstrap_wanted && !over;
                    end
                end
                KIND_SLICE:
                begin
                    if (hok && len >= SLICE_MIN_LEN)
                    begin
                        result.verdict     = VERDICT_SLICE;
                        result.forward_now = live_forward;
                        if (gop_valid_reg && !gop_full_reg)
                        begin
                            if (over)
                            begin
                                gop_full_next     = 1'b1;
                                result.gop_action = GOP_SPILL;
                            end
                            else
                            begin
                                gop_used_next     = sum[FILL_W-1:0];
                                result.gop_action = GOP_APPEND;
                            end
                        end
                    end
                end
                default:
                begin
                    result.verdict = VERDICT_DROP;
                end
            endcase
        end

        result.gop_fill = gop_used_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sps_seen_reg  <= 1'b0;
            pps_seen_reg  <= 1'b0;
            gop_valid_reg <= 1'b0;
            gop_full_reg  <= 1'b0;
            gop_used_reg  <= '0;
        end
        else
        begin
            sps_seen_reg  <= sps_seen_next;
            pps_seen_reg  <= pps_seen_next;
            gop_valid_reg <= gop_valid_next;
            gop_full_reg  <= gop_full_next;
            gop_used_reg  <= gop_used_next;
        end
    end

    `ANX_ASSERT_IMP(a_full_needs_valid, clk, rst_n, gop_full_reg, gop_valid_reg)
    `ANX_ASSERT_IMP(a_idr_after_ps, clk, rst_n, result.valid && result.verdict == VERDICT_IDR,
                    sps_seen_reg && pps_seen_reg)
    `ANX_ASSERT_NEXT(a_idr_sets_valid, clk, rst_n,
                     result.valid && result.verdict == VERDICT_IDR, gop_valid_reg)

endmodule

@@ test/tb_annexb_nal_extract_classify.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_annexb_nal_extract_classify
// Self-checking bench for the Annex-B NAL extractor/classifier. A driver
// feeds stream bytes and restarts from a queue, a scoreboard model grades
// every completed NAL, and a monitor compares each verdict transaction.
// Runs go through several GOP cache capacities.
// ----------------------------------------------------------------------------
module tb_annexb_nal_extract_classify;
    import anx_pkg::*;

    localparam logic [4:0] KIND_SEI   = 5'd6;
    localparam int         IDLE_LIMIT = 5000;

    logic clk;
    logic rst_n;

    anx_in_if  bs_if ();
    anx_out_if res_if ();
    anx_cfg_if cfg_if ();

    annexb_nal_extract_classify dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (bs_if),
        .result      (res_if),
        .cfg         (cfg_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // stream model state
    // ------------------------------------------------------------------
    logic [1:0]        zero_cnt     = '0;
    logic              in_nal       = 1'b0;
    logic [LEN_W-1:0]  nal_bytes    = '0;
    logic [LEN_W-1:0]  nal_kept     = '0;
    logic              nal_overlong = 1'b0;
    logic [7:0]        nal_hdr      = '0;
    logic [7:0]        nal_profile  = '0;
    logic              sps_have     = 1'b0;
    logic              pps_have     = 1'b0;
    logic              gop_live     = 1'b0;
    logic              gop_over     = 1'b0;
    logic [FILL_W-1:0] cache_fill   = '0;
    logic [FILL_W-1:0] gop_cap      = CAP_RESET;

    in_item_t    stream_q [$];
    nal_result_t verdict_q [$];

    int src_gap;
    int sink_hold;
    int long_holds;
    int results_taken;
    int idle_cycles;
    int err_cnt = 0;
    int gen_zeros = 0;
    int gen_items = 0;
    int gen_nals = 0;

    logic [7:0] sps_profiles [7] = '{8'd66, 8'd77, 8'd88, 8'd100, 8'd110, 8'd122, 8'd244};

    function automatic logic [1:0] gop_charge(input logic [LEN_W-1:0] len,
                                              input logic [1:0] ok_code);
        logic [26:0] total;
        total = 27'(cache_fill) + 27'(len) + 27'(ENTRY_PREFIX);
        if (total > 27'(gop_cap))
        begin
            gop_over = 1'b1;
            return GOP_SPILL;
        end
        cache_fill = total[FILL_W-1:0];
        return ok_code;
    endfunction

    function automatic nal_result_t grade_nal(input logic live, input logic want);
        nal_result_t r;
        logic        hdr_ok;
        r = '0;
        r.valid = 1'b1;
        r.verdict = VERDICT_DROP;
        r.gop_action = GOP_NONE;
        r.nal_kind = nal_hdr[4:0];
        r.nal_length = nal_kept;
        hdr_ok = (nal_hdr[6:5] != 2'b00);
        if (!nal_overlong && nal_kept != '0 && !nal_hdr[7])
        begin
            case (nal_hdr[4:0])
                KIND_SPS:
                    if (hdr_ok && nal_kept >= SPS_MIN_LEN && nal_kept <= SPS_MAX_LEN &&
                        nal_profile inside {8'd66, 8'd77, 8'd88, 8'd100, 8'd110, 8'd122,
                                            8'd244})
                    begin
                        r.verdict = VERDICT_SPS;
                        sps_have = 1'b1;
                        r.forward_now = live;
                    end
                KIND_PPS:
                    if (hdr_ok && nal_kept >= PPS_MIN_LEN && nal_kept <= PPS_MAX_LEN)
                    begin
                        r.verdict = VERDICT_PPS;
                        pps_have = 1'b1;
                        r.forward_now = live;
                    end
                KIND_IDR:
                    if (hdr_ok && nal_kept >= IDR_MIN_LEN && sps_have && pps_have)
                    begin
                        r.verdict = VERDICT_IDR;
                        cache_fill = '0;
                        gop_over = 1'b0;
                        gop_live = 1'b1;
                        r.gop_action = gop_charge(nal_kept, GOP_RESTART);
                        r.forward_now = live;
                        r.bootstrap_request = !live && want && !gop_over;
                    end
                KIND_SLICE:
                    if (hdr_ok && nal_kept >= SLICE_MIN_LEN)
                    begin
                        r.verdict = VERDICT_SLICE;
                        if (gop_live && !gop_over)
                            r.gop_action = gop_charge(nal_kept, GOP_APPEND);
                        r.forward_now = live;
                    end
                default: ;
            endcase
        end
        r.gop_fill = cache_fill;
        return r;
    endfunction

    function automatic void clear_nal();
        nal_bytes = '0;
        nal_kept = '0;
        nal_overlong = 1'b0;
        nal_hdr = '0;
        nal_profile = '0;
    endfunction

    // one accepted stream transaction
    function automatic void track_stream_item(input logic act, input logic [7:0] b,
                                              input logic live, input logic want);
        if (act == ACT_RESTART)
        begin
            zero_cnt = '0;
            in_nal = 1'b0;
            clear_nal();
            return;
        end
        if (b == 8'h01 && zero_cnt >= 2'd2)
        begin
            if (in_nal && nal_kept != '0)
                verdict_q.push_back(grade_nal(live, want));
            in_nal = 1'b1;
            zero_cnt = '0;
            clear_nal();
            return;
        end
        if (b == 8'h00)
        begin
            if (zero_cnt < 2'd2)
                zero_cnt = zero_cnt + 2'd1;
        end
        else
            zero_cnt = '0;
        if (in_nal)
        begin
            if (nal_bytes == '0)
                nal_hdr = b;
            else if (nal_bytes == LEN_W'(1))
                nal_profile = b;
            if (nal_bytes <= MAX_NAL)
                nal_bytes = nal_bytes + LEN_W'(1);
            if (b != 8'h00)
            begin
                nal_kept = nal_bytes;
                if (nal_kept > MAX_NAL)
                    nal_overlong = 1'b1;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // stream driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drv
        in_item_t nxt;
        int       r;
        if (!rst_n)
        begin
            bs_if.valid <= 1'b0;
            bs_if.action <= ACT_BYTE;
            bs_if.data_byte <= '0;
            bs_if.live_forward <= 1'b0;
            bs_if.bootstrap_wanted <= 1'b0;
            src_gap <= 0;
        end
        else
        begin
            if (bs_if.valid && bs_if.ready)
                track_stream_item(bs_if.action, bs_if.data_byte, bs_if.live_forward,
                                  bs_if.bootstrap_wanted);
            if (!bs_if.valid || bs_if.ready)
            begin
                if (src_gap != 0)
                begin
                    src_gap <= src_gap - 1;
                    bs_if.valid <= 1'b0;
                end
                else if (stream_q.size() != 0)
                begin
                    nxt = stream_q.pop_front();
                    bs_if.valid <= 1'b1;
                    bs_if.action <= nxt.action;
                    bs_if.data_byte <= nxt.data_byte;
                    bs_if.live_forward <= nxt.live_forward;
                    bs_if.bootstrap_wanted <= nxt.bootstrap_wanted;
                    r = int'($urandom_range(0, 99));
                    if (r < 65)
                        src_gap <= 0;
                    else if (r < 92)
                        src_gap <= int'($urandom_range(1, 3));
                    else if (r < 98)
                        src_gap <= int'($urandom_range(4, 12));
                    else
                        src_gap <= int'($urandom_range(20, 60));
                end
                else
                    bs_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result sink: random backpressure plus two long holds
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : rx
        int r;
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            sink_hold <= 0;
            long_holds <= 0;
        end
        else if (sink_hold != 0)
        begin
            sink_hold <= sink_hold - 1;
            res_if.ready <= 1'b0;
        end
        else if (long_holds < 2 && res_if.valid && stream_q.size() > 40 &&
                 results_taken >= 8 + 16 * long_holds)
        begin
            // stream keeps coming, so the input side has to back up
            sink_hold <= 300;
            long_holds <= long_holds + 1;
            res_if.ready <= 1'b0;
        end
        else
        begin
            r = int'($urandom_range(0, 99));
            if (r < 3)
            begin
                sink_hold <= int'($urandom_range(8, 40));
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= (r >= 25);
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            err_cnt++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : mon
        nal_result_t exp_r;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            results_taken <= results_taken + 1;
            if (verdict_q.size() == 0)
            begin
                err_cnt++;
                $display("%0t: unexpected result transaction, expected none, actual verdict %0d",
                         $time, res_if.verdict);
            end
            else
            begin
                exp_r = verdict_q.pop_front();
                check_field("verdict", 32'(exp_r.verdict), 32'(res_if.verdict));
                check_field("nal_kind", 32'(exp_r.nal_kind), 32'(res_if.nal_kind));
                check_field("nal_length", 32'(exp_r.nal_length), 32'(res_if.nal_length));
                check_field("forward_now", 32'(exp_r.forward_now), 32'(res_if.forward_now));
                check_field("gop_action", 32'(exp_r.gop_action), 32'(res_if.gop_action));
                check_field("gop_fill", 32'(exp_r.gop_fill), 32'(res_if.gop_fill));
                check_field("bootstrap_request", 32'(exp_r.bootstrap_request),
                            32'(res_if.bootstrap_request));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n)
            idle_cycles <= 0;
        else if ((bs_if.valid && bs_if.ready) || (res_if.valid && res_if.ready) ||
                 (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("FAIL annexb_nal_extract_classify");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_item(input logic act, input logic [7:0] b, input logic live,
                            input logic want);
        in_item_t it;
        it.action = act;
        it.data_byte = b;
        it.live_forward = live;
        it.bootstrap_wanted = want;
        stream_q.push_back(it);
        gen_items++;
        if (act == ACT_RESTART || b != 8'h00)
            gen_zeros = 0;
        else if (gen_zeros < 2)
            gen_zeros++;
    endtask

    task automatic add_byte(input logic [7:0] b);
        add_item(ACT_BYTE, b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // start code; the flags ride on the 01 that closes the previous NAL
    task automatic add_start(input logic four, input logic live, input logic want);
        if (four)
            add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'h00);
        add_item(ACT_BYTE, 8'h01, live, want);
    endtask

    task automatic add_nal(input logic [7:0] hdr, input logic [7:0] prof, input int len,
                           input int tz);
        logic [7:0] b;
        add_byte(hdr);
        for (int i = 1; i < len; i++)
        begin
            if (i == 1)
                b = prof;
            else if (i == len - 1)
                b = 8'($urandom_range(1, 255));
            else if ($urandom_range(0, 7) == 0)
                b = 8'h00;
            else
                b = 8'($urandom_range(0, 255));
            // keep body bytes from forming a start code
            if (gen_zeros >= 2 && b == 8'h01)
                b = 8'h03;
            add_byte(b);
        end
        for (int i = 0; i < tz; i++)
            add_byte(8'h00);
    endtask

    task automatic run_random_phase(input int min_items, input int min_nals);
        int         first_items;
        int         first_nals;
        int         r;
        int         nb;
        int         len;
        logic [4:0] kind;
        logic [1:0] nri;
        logic [7:0] prof;
        logic [7:0] b;
        first_items = gen_items;
        first_nals = gen_nals;
        while (gen_items - first_items < min_items || gen_nals - first_nals < min_nals)
        begin
            r = int'($urandom_range(0, 99));
            if (r < 4)
                add_item(ACT_RESTART, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            else if (r < 12)
            begin
                // junk bytes, heavy on 00 and 01 so stray start codes show up
                nb = int'($urandom_range(1, 8));
                for (int i = 0; i < nb; i++)
                begin
                    case ($urandom_range(0, 5))
                        0, 1, 2: b = 8'h00;
                        3:       b = 8'h01;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                    add_byte(b);
                end
            end
            else
            begin
                add_start(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                prof = 8'($urandom_range(0, 255));
                r = int'($urandom_range(0, 99));
                if (r < 14)
                begin
                    kind = KIND_SPS;
                    len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 140))
                                                      : int'($urandom_range(4, 24));
                    if ($urandom_range(0, 5) != 0)
                        prof = sps_profiles[$urandom_range(0, 6)];
                end
                else if (r < 28)
                begin
                    kind = KIND_PPS;
                    len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 100))
                                                      : int'($urandom_range(2, 12));
                end
                else if (r < 48)
                begin
                    kind = KIND_IDR;
                    len = int'($urandom_range(14, 40));
                end
                else if (r < 85)
                begin
                    kind = KIND_SLICE;
                    len = int'($urandom_range(2, 30));
                end
                else
                begin
                    kind = 5'($urandom_range(0, 31));
                    len = int'($urandom_range(1, 20));
                end
                nri = ($urandom_range(0, 7) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
                add_nal({1'($urandom_range(0, 19) == 0), nri, kind}, prof, len,
                        ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 3)) : 0);
                gen_nals++;
            end
        end
        add_start(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    endtask

    // wait until the block has gone quiet
    task automatic drain();
        while (stream_q.size() != 0 || bs_if.valid || verdict_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [FILL_W-1:0] cap);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.gop_capacity <= cap;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        gop_cap = cap;
        cfg_if.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin : main
        rst_n = 1'b0;
        bs_if.valid = 1'b0;
        bs_if.action = ACT_BYTE;
        bs_if.data_byte = '0;
        bs_if.live_forward = 1'b0;
        bs_if.bootstrap_wanted = 1'b0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.gop_capacity = '0;
        results_taken = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset capacity
        add_byte(8'h55);                       // before any start code: ignored
        add_start(1'b0, 1'b0, 1'b0);
        add_nal({1'b0, 2'd3, KIND_SPS}, 8'd66, 4, 0);
        add_start(1'b1, 1'b1, 1'b0);           // SPS forwarded live
        add_nal({1'b0, 2'd3, KIND_PPS}, 8'hff, 2, 2);
        add_start(1'b0, 1'b0, 1'b0);
        add_nal({1'b0, 2'd2, KIND_IDR}, 8'h88, 16, 1);
        add_start(1'b0, 1'b0, 1'b1);           // IDR fits: bootstrap
        add_nal({1'b0, 2'd1, KIND_SLICE}, 8'h9a, 4, 0);
        add_start(1'b0, 1'b1, 1'b1);           // both flags, live wins
        add_nal({1'b1, 2'd3, KIND_SLICE}, 8'h9a, 4, 0);
        add_start(1'b0, 1'b0, 1'b0);           // forbidden bit set: dropped
        add_nal({1'b0, 2'd0, KIND_SLICE}, 8'h9a, 4, 0);
        add_start(1'b0, 1'b0, 1'b0);           // nri zero: dropped
        add_start(1'b0, 1'b0, 1'b0);           // empty NAL, no result
        add_nal({1'b0, 2'd3, KIND_IDR}, 8'h11, 8, 0);
        add_item(ACT_RESTART, 8'hff, 1'b1, 1'b1);
        add_start(1'b1, 1'b0, 1'b0);
        add_nal({1'b0, 2'd3, KIND_SEI}, 8'h05, 3, 0);
        add_start(1'b0, 1'b1, 1'b0);
        drain();

        set_capacity(FILL_W'(33554431));
        run_random_phase(170, 8);
        drain();

        set_capacity('0);                      // every append overflows
        run_random_phase(170, 8);
        drain();

        set_capacity(FILL_W'(1024));
        run_random_phase(170, 8);
        drain();

        set_capacity(FILL_W'($urandom_range(60, 600)));
        run_random_phase(170, 8);
        drain();

        if (err_cnt == 0)
            $display("PASS annexb_nal_extract_classify");
        else
            $display("FAIL annexb_nal_extract_classify");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/anx_pkg.sv
src/anx_in_if.sv
src/anx_out_if.sv
src/anx_cfg_if.sv
src/anx_scanner.sv
src/anx_classifier.sv
src/annexb_nal_extract_classify.sv
test/tb_annexb_nal_extract_classify.sv
